// ===== rtl/deadline_timer_table_core_defines.svh =====
// ----------------------------------------------------------------------------
// deadline timer table core assertion macros
// shared concurrent assertion helpers for the timer table rtl
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_TABLE_CORE_DEFINES_SVH
`define DEADLINE_TIMER_TABLE_CORE_DEFINES_SVH

// assertion on clk_i, quiet while rst_ni is low
`define DTTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// assertion on clk_i that also holds during reset
`define DTTC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/dttc_pkg.sv =====
// ----------------------------------------------------------------------------
// dttc_pkg
// types and constants shared by the deadline timer table rtl
// ----------------------------------------------------------------------------
package dttc_pkg;

  // field widths of the request and response transactions
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned INDEX_W   = 5;
  localparam int unsigned QUEUE_W   = 4;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned PAYLOAD_W = QUEUE_W + BYTE_W;

  // no armed deadline
  localparam logic [TICK_W-1:0] NO_DEADLINE = 32'hffff_ffff;

  // events emitted per tick at most
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 3'd0,
    MODE_FREE  = 3'd1,
    MODE_BIND  = 3'd2,
    MODE_ARM   = 3'd3,
    MODE_TICK  = 3'd4
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_NONE  = 2'd1,
    KIND_FIRED = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    FLAG_FREE  = 2'd0,
    FLAG_ALLOC = 2'd1,
    FLAG_ARMED = 2'd2
  } flag_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] timer_index;
    logic [QUEUE_W-1:0] fifo_id;
    logic [BYTE_W-1:0]  event_data;
    logic [TICK_W-1:0]  timeout_ticks;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SLOT_W-1:0]  slot;
    logic [QUEUE_W-1:0] dest_queue;
    logic [BYTE_W-1:0]  fired_byte;
    logic               last;
  } rsp_t;

endpackage

// ===== rtl/dttc_if.sv =====
// ----------------------------------------------------------------------------
// dttc request and response channels
// valid/ready channels carrying one request or one response per transaction
// ----------------------------------------------------------------------------
interface dttc_req_if;
  import dttc_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dttc_rsp_if;
  import dttc_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/deadline_timer_table_core.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_table_core
// software timer table with shared tick counter and earliest-deadline scan
// ----------------------------------------------------------------------------
//  channel  | dir | transaction
//  ---------+-----+----------------------------------------------------------
//  req_i    | in  | alloc, free, bind, arm or tick request
//  rsp_o    | out | alloc grant, no-free report or fired timer event
//
//  free, bind, arm and a tick that is not due complete in the idle state
//  alloc walks the slot flags one per cycle while the output register is free
//  a due tick reads one slot per cycle from the deadline and payload rams,
//  except while the scan stalls with the pending and output registers full
//  reset clears the slot flags at once; the rams need no clearing pass
//  the scan holds its slot while both the pending and output registers wait
// ----------------------------------------------------------------------------
`include "deadline_timer_table_core_defines.svh"

module deadline_timer_table_core #(
  parameter int unsigned TIMER_COUNT = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  dttc_req_if.sink   req_i,
  dttc_rsp_if.source rsp_o
);
  import dttc_pkg::*;

  localparam int unsigned    IDX_W    = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [TICK_W-1:0]   now_q, now_d;
  logic [TICK_W-1:0]   earliest_q, earliest_d;
  logic [CNT_W-1:0]    fire_cnt_q, fire_cnt_d;
  logic                pend_valid_q, pend_valid_d;
  rsp_t                pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  rsp_t                out_q, out_d;
  flag_e               flags_q [TIMER_COUNT];

  logic                flag_we;
  logic [IDX_W-1:0]    flag_addr;
  flag_e               flag_wval;

  logic                dl_we;
  logic                pl_we;
  logic [IDX_W-1:0]    wr_addr;
  logic [IDX_W-1:0]    rd_addr;
  logic [TICK_W-1:0]   dl_wdata;
  logic [PAYLOAD_W-1:0] pl_wdata;
  logic [TICK_W-1:0]   dl_rdata;
  logic [PAYLOAD_W-1:0] pl_rdata;

  logic                req_accept;
  logic                out_free;
  logic                in_table;
  logic [IDX_W-1:0]    req_addr;
  logic [TICK_W-1:0]   arm_deadline;
  logic [TICK_W-1:0]   now_inc;
  logic                slot_armed;
  logic                slot_due;
  logic                slot_fire;
  logic                scan_stall;

  // handshake and request decode
  assign req_i.ready  = (state_q == ST_IDLE);
  assign req_accept   = req_i.valid && req_i.ready;
  assign out_free     = !out_valid_q || rsp_o.ready;
  assign in_table     = (32'(req_i.data.timer_index) < TIMER_COUNT);
  assign req_addr     = IDX_W'(req_i.data.timer_index);
  assign arm_deadline = now_q + req_i.data.timeout_ticks;
  assign now_inc      = now_q + 32'd1;

  // scan evaluation of the slot whose ram data is on the read port
  assign slot_armed = (flags_q[idx_q] == FLAG_ARMED);
  assign slot_due   = (dl_rdata <= now_q);
  assign slot_fire  = slot_armed && slot_due && (fire_cnt_q < CNT_W'(MAX_RESULTS));
  assign scan_stall = slot_fire && pend_valid_q && !out_free;

  // deadline and payload memories
  dttc_ram #(
    .WIDTH (TICK_W),
    .DEPTH (TIMER_COUNT)
  ) u_deadline_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (wr_addr),
    .wdata_i (dl_wdata),
    .raddr_i (rd_addr),
    .rdata_o (dl_rdata)
  );

  dttc_ram #(
    .WIDTH (PAYLOAD_W),
    .DEPTH (TIMER_COUNT)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (pl_we),
    .waddr_i (wr_addr),
    .wdata_i (pl_wdata),
    .raddr_i (rd_addr),
    .rdata_o (pl_rdata)
  );

  // sequencer: next state, ram accesses and result registers
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    now_d        = now_q;
    earliest_d   = earliest_q;
    fire_cnt_d   = fire_cnt_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_d        = out_q;
    flag_we      = 1'b0;
    flag_addr    = idx_q;
    flag_wval    = FLAG_ALLOC;
    dl_we        = 1'b0;
    pl_we        = 1'b0;
    wr_addr      = req_addr;
    dl_wdata     = arm_deadline;
    pl_wdata     = {req_i.data.fifo_id, req_i.data.event_data};
    rd_addr      = '0;

    case (state_q)
      ST_IDLE: begin
        if (req_accept) begin
          case (req_i.data.mode)
            MODE_ALLOC: begin
              idx_d   = '0;
              state_d = ST_ALLOC;
            end
            MODE_FREE: begin
              if (in_table) begin
                flag_we   = 1'b1;
                flag_addr = req_addr;
                flag_wval = FLAG_FREE;
              end
            end
            MODE_BIND: begin
              pl_we = in_table;
            end
            MODE_ARM: begin
              if (in_table) begin
                dl_we     = 1'b1;
                flag_we   = 1'b1;
                flag_addr = req_addr;
                flag_wval = FLAG_ARMED;
                if (earliest_q > arm_deadline) begin
                  earliest_d = arm_deadline;
                end
              end
            end
            MODE_TICK: begin
              now_d = now_inc;
              if (earliest_q <= now_inc) begin
                earliest_d = NO_DEADLINE;
                idx_d      = '0;
                fire_cnt_d = '0;
                state_d    = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_ALLOC: begin
        if (out_free) begin
          out_d.dest_queue = '0;
          out_d.fired_byte = '0;
          out_d.last       = 1'b1;
          if (flags_q[idx_q] == FLAG_FREE) begin
            flag_we     = 1'b1;
            flag_wval   = FLAG_ALLOC;
            out_valid_d = 1'b1;
            out_d.kind  = KIND_ALLOC;
            out_d.slot  = SLOT_W'(idx_q);
            state_d     = ST_IDLE;
          end else if (idx_q == LAST_IDX) begin
            out_valid_d = 1'b1;
            out_d.kind  = KIND_NONE;
            out_d.slot  = '0;
            state_d     = ST_IDLE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end

      ST_SCAN: begin
        // hold the read address on a stall so the data stays on the port
        rd_addr = scan_stall ? idx_q : (idx_q + IDX_W'(1));
        if (!scan_stall) begin
          if (slot_fire) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_d       = pend_q;
            end
            pend_valid_d      = 1'b1;
            pend_d.kind       = KIND_FIRED;
            pend_d.slot       = SLOT_W'(idx_q);
            pend_d.dest_queue = pl_rdata[PAYLOAD_W-1:BYTE_W];
            pend_d.fired_byte = pl_rdata[BYTE_W-1:0];
            pend_d.last       = 1'b0;
            flag_we           = 1'b1;
            flag_wval         = FLAG_ALLOC;
            fire_cnt_d        = fire_cnt_q + CNT_W'(1);
          end else if (slot_armed && (earliest_q > dl_rdata)) begin
            earliest_d = dl_rdata;
          end
          if (idx_q == LAST_IDX) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end

      ST_FLUSH: begin
        // the held event is the final one of this tick
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_d        = pend_q;
          out_d.last   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      now_q        <= '0;
      earliest_q   <= NO_DEADLINE;
      fire_cnt_q   <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      now_q        <= now_d;
      earliest_q   <= earliest_d;
      fire_cnt_q   <= fire_cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // slot flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TIMER_COUNT; i++) begin
        flags_q[i] <= FLAG_FREE;
      end
    end else if (flag_we) begin
      flags_q[flag_addr] <= flag_wval;
    end
  end

  // result payload registers
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // checks
  `DTTC_ASSERT(a_idle_no_pending, req_i.ready |-> !pend_valid_q, "pending event left in idle")
  `DTTC_ASSERT(a_fire_cnt_bound, fire_cnt_q <= CNT_W'(MAX_RESULTS), "too many events on a tick")
  `DTTC_ASSERT(a_scan_starts_clear, (state_q == ST_SCAN && $past(state_q) == ST_IDLE) |-> earliest_q == NO_DEADLINE, "scan began without clearing earliest")
  `DTTC_ASSERT(a_pend_only_in_scan, pend_valid_q |-> (state_q == ST_SCAN || state_q == ST_FLUSH), "pending event outside tick scan")
  `DTTC_ASSERT_ALWAYS(a_no_overwrite, (out_valid_q && !rsp_o.ready) |=> $stable(out_q), "unaccepted response overwritten")

endmodule

// ===== rtl/dttc_ram.sv =====
// ----------------------------------------------------------------------------
// dttc_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module dttc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port, read returns old data on collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== dv/timer_table_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timer_table_monitor
// watches the request and response channels of the deadline timer table,
// keeps a shadow copy of the slot table and tick counter, works out the
// responses each accepted request causes and compares them in order
// ----------------------------------------------------------------------------
module timer_table_monitor #(
  parameter int unsigned TIMER_COUNT = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dttc_req_if        req_i,
  dttc_rsp_if        rsp_i,
  output int         errors_o,
  output int         pending_o,
  output int         grants_o,
  output int         full_o,
  output int         fired_o
);
  import dttc_pkg::*;

  // shadow slot table
  flag_e             slot_flag [TIMER_COUNT];
  logic [TICK_W-1:0] slot_due  [TIMER_COUNT];
  logic [QUEUE_W-1:0] slot_dest [TIMER_COUNT];
  logic [BYTE_W-1:0] slot_evt  [TIMER_COUNT];
  logic [TICK_W-1:0] now_cnt;
  logic [TICK_W-1:0] earliest_due;

  // responses owed by the block, oldest first
  rsp_t owed_rsp_q [$];

  int errors;
  int grants;
  int fulls;
  int fired;

  // update the shadow table for one request and queue the responses it causes
  task automatic predict_request(input req_t r);
    rsp_t              e;
    int                n;
    bit                granted;
    logic [TICK_W-1:0] due;
    n = 0;
    granted = 1'b0;
    e = '0;
    case (r.mode)
      MODE_ALLOC: begin
        for (int i = 0; i < TIMER_COUNT; i++) begin
          if (!granted && slot_flag[i] == FLAG_FREE) begin
            slot_flag[i] = FLAG_ALLOC;
            e.kind = KIND_ALLOC;
            e.slot = SLOT_W'(i);
            granted = 1'b1;
          end
        end
        if (!granted) e.kind = KIND_NONE;
        owed_rsp_q.push_back(e);
        n = 1;
      end
      MODE_FREE: begin
        if (32'(r.timer_index) < TIMER_COUNT) slot_flag[r.timer_index] = FLAG_FREE;
      end
      MODE_BIND: begin
        if (32'(r.timer_index) < TIMER_COUNT) begin
          slot_dest[r.timer_index] = r.fifo_id;
          slot_evt[r.timer_index]  = r.event_data;
        end
      end
      MODE_ARM: begin
        if (32'(r.timer_index) < TIMER_COUNT) begin
          due = now_cnt + r.timeout_ticks;
          slot_due[r.timer_index]  = due;
          slot_flag[r.timer_index] = FLAG_ARMED;
          if (earliest_due > due) earliest_due = due;
        end
      end
      MODE_TICK: begin
        now_cnt = now_cnt + 32'd1;
        // scan only once the earliest deadline is reached; rebuild it as we go
        if (earliest_due <= now_cnt) begin
          earliest_due = NO_DEADLINE;
          for (int i = 0; i < TIMER_COUNT; i++) begin
            if (slot_flag[i] == FLAG_ARMED) begin
              if (slot_due[i] <= now_cnt && n < MAX_RESULTS) begin
                slot_flag[i] = FLAG_ALLOC;
                e = '0;
                e.kind       = KIND_FIRED;
                e.slot       = SLOT_W'(i);
                e.dest_queue = slot_dest[i];
                e.fired_byte = slot_evt[i];
                owed_rsp_q.push_back(e);
                n++;
              end else if (earliest_due > slot_due[i]) begin
                earliest_due = slot_due[i];
              end
            end
          end
        end
      end
      default: ;
    endcase
    // mark the final response of this request
    if (n > 0) begin
      e = owed_rsp_q.pop_back();
      e.last = 1'b1;
      owed_rsp_q.push_back(e);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_response(input rsp_t act);
    rsp_t want;
    case (act.kind)
      KIND_ALLOC: grants++;
      KIND_NONE:  fulls++;
      KIND_FIRED: fired++;
      default: ;
    endcase
    if (owed_rsp_q.size() == 0) begin
      $display("%0t: unexpected response, expected none, actual kind %0d slot %0d",
               $time, act.kind, act.slot);
      errors++;
    end else begin
      want = owed_rsp_q.pop_front();
      check_field("kind", 32'(want.kind), 32'(act.kind));
      check_field("slot", 32'(want.slot), 32'(act.slot));
      check_field("dest_queue", 32'(want.dest_queue), 32'(act.dest_queue));
      check_field("fired_byte", 32'(want.fired_byte), 32'(act.fired_byte));
      check_field("last", 32'(want.last), 32'(act.last));
    end
  endtask

  // sample both channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TIMER_COUNT; i++) begin
        slot_flag[i] = FLAG_FREE;
        slot_due[i]  = '0;
        slot_dest[i] = '0;
        slot_evt[i]  = '0;
      end
      now_cnt      = '0;
      earliest_due = NO_DEADLINE;
      owed_rsp_q.delete();
      errors = 0;
      grants = 0;
      fulls  = 0;
      fired  = 0;
    end else begin
      if (req_i.valid && req_i.ready) predict_request(req_i.data);
      if (rsp_i.valid && rsp_i.ready) check_response(rsp_i.data);
    end
    errors_o  <= errors;
    pending_o <= owed_rsp_q.size();
    grants_o  <= grants;
    full_o    <= fulls;
    fired_o   <= fired;
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the deadline timer table: a short directed pass over alloc,
// free, bind, arm, tick and the unused modes, then random timer sequences,
// table fills and loose requests, with random idling on both channels
// ----------------------------------------------------------------------------
module tb;
  import dttc_pkg::*;

  localparam int unsigned TIMERS        = 32;
  localparam int unsigned RANDOM_ITEMS  = 235;
  localparam int unsigned QUIET_TAIL    = 40;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;

  logic clk;
  logic rst_n;

  dttc_req_if req_if ();
  dttc_rsp_if rsp_if ();

  int errors;
  int pending;
  int grants;
  int fulls;
  int fired;

  int unsigned sent_cnt;
  int unsigned quiet_from;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned fills;
  bit [TIMERS-1:0] ever_bound;

  deadline_timer_table_core #(
    .TIMER_COUNT (TIMERS)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  timer_table_monitor #(
    .TIMER_COUNT (TIMERS)
  ) u_monitor (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_i     (req_if),
    .rsp_i     (rsp_if),
    .errors_o  (errors),
    .pending_o (pending),
    .grants_o  (grants),
    .full_o    (fulls),
    .fired_o   (fired)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // response side backpressure in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sent_cnt < quiet_from && $urandom_range(0, 99) < stall_pct) begin
      rsp_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic req_t make_req(input logic [MODE_W-1:0] m, input int unsigned idx,
                                    input int unsigned dest, input int unsigned evt,
                                    input logic [TICK_W-1:0] delay);
    req_t r;
    r.mode          = m;
    r.timer_index   = INDEX_W'(idx);
    r.fifo_id       = QUEUE_W'(dest);
    r.event_data    = BYTE_W'(evt);
    r.timeout_ticks = delay;
    return r;
  endfunction

  // mostly short delays, some that wrap to the past, some far away
  function automatic logic [TICK_W-1:0] pick_delay();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return $urandom_range(0, 6);
    if (p < 75) return NO_DEADLINE - $urandom_range(0, 3);
    if (p < 85) return $urandom_range(7, 40);
    return $urandom;
  endfunction

  // only slots that were bound may be armed, so no fired event reads stale data
  function automatic int unsigned bound_slot();
    int unsigned s;
    s = $urandom_range(0, TIMERS - 1);
    while (!ever_bound[s]) s = $urandom_range(0, TIMERS - 1);
    return s;
  endfunction

  // one request transaction, with an optional idle burst in front
  task automatic send(input req_t r);
    if (sent_cnt < quiet_from && $urandom_range(0, 99) < gap_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk); while (!req_if.ready);
    sent_cnt++;
    if (r.mode == MODE_BIND) ever_bound[r.timer_index] = 1'b1;
    // change the idling pattern every 40 transactions
    if (sent_cnt % 40 == 0) begin
      case ($urandom_range(0, 2))
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 15; stall_pct = 10; end
        default: begin gap_pct = 40; stall_pct = 30; end
      endcase
    end
  endtask

  // bind and arm a few slots, maybe cancel one, then tick
  task automatic timer_burst();
    int unsigned cnt;
    int unsigned s;
    cnt = $urandom_range(1, 4);
    repeat (cnt) begin
      s = $urandom_range(0, TIMERS - 1);
      if ($urandom_range(0, 1) == 1) send(make_req(MODE_ALLOC, $urandom, $urandom, $urandom,
                                                   $urandom));
      send(make_req(MODE_BIND, s, $urandom, $urandom, $urandom));
      send(make_req(MODE_ARM, s, $urandom, $urandom, pick_delay()));
    end
    if ($urandom_range(0, 3) == 0) send(make_req(MODE_FREE, $urandom, $urandom, $urandom,
                                                 $urandom));
    repeat ($urandom_range(1, 8)) send(make_req(MODE_TICK, $urandom, $urandom, $urandom,
                                                $urandom));
  endtask

  // allocate past the table size, then release a handful of slots
  task automatic fill_table();
    repeat (TIMERS + 2) send(make_req(MODE_ALLOC, $urandom, $urandom, $urandom, $urandom));
    repeat ($urandom_range(4, 12)) send(make_req(MODE_FREE, $urandom, $urandom, $urandom,
                                                 $urandom));
    fills++;
  endtask

  // loose request of any mode with random fields
  task automatic random_item();
    req_t        r;
    int unsigned p;
    r = make_req(MODE_TICK, $urandom, $urandom, $urandom, $urandom);
    p = $urandom_range(0, 99);
    if (p < 15) r.mode = MODE_ALLOC;
    else if (p < 27) r.mode = MODE_FREE;
    else if (p < 45) r.mode = MODE_BIND;
    else if (p < 65) begin
      r.mode = MODE_ARM;
      r.timer_index = INDEX_W'(bound_slot());
      if ($urandom_range(0, 1) == 1) r.timeout_ticks = pick_delay();
    end
    else if (p < 94) r.mode = MODE_TICK;
    else r.mode = MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
    send(r);
  endtask

  initial begin
    int unsigned directed_n;
    int unsigned pick;
    rst_n        = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    sent_cnt     = 0;
    quiet_from   = 32'hffff_ffff;
    gap_pct      = 15;
    stall_pct    = 10;
    stall_left   = 0;
    idle_cycles  = 0;
    fills        = 0;
    ever_bound   = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tick with nothing armed, then grants of the two lowest slots
    send(make_req(MODE_TICK, 0, 0, 0, 0));
    send(make_req(MODE_ALLOC, 0, 0, 0, 0));
    send(make_req(MODE_ALLOC, 0, 0, 0, 0));
    // extremes of queue id and event byte on the first and last slot
    send(make_req(MODE_BIND, 0, 15, 8'hff, 0));
    send(make_req(MODE_BIND, TIMERS - 1, 0, 8'h00, 0));
    send(make_req(MODE_BIND, 1, 4'ha, 8'h5a, 0));
    // zero delay fires on the next tick
    send(make_req(MODE_ARM, 0, 0, 0, 0));
    send(make_req(MODE_TICK, 0, 0, 0, 0));
    // full delay wraps to a deadline in the past, armed on a free slot
    send(make_req(MODE_ARM, TIMERS - 1, 0, 0, NO_DEADLINE));
    send(make_req(MODE_ARM, 1, 0, 0, 2));
    send(make_req(MODE_TICK, 0, 0, 0, 0));
    send(make_req(MODE_TICK, 0, 0, 0, 0));
    // free cancels an armed slot, the next tick scans and finds nothing
    send(make_req(MODE_ARM, 0, 0, 0, 1));
    send(make_req(MODE_FREE, 0, 0, 0, 0));
    send(make_req(MODE_TICK, 0, 0, 0, 0));
    // three slots due on the same tick fire in slot order
    send(make_req(MODE_ARM, TIMERS - 1, 0, 0, 3));
    send(make_req(MODE_ARM, 1, 0, 0, 3));
    send(make_req(MODE_ARM, 0, 0, 0, 3));
    repeat (3) send(make_req(MODE_TICK, 0, 0, 0, 0));
    // unused modes, the first and last with all fields high
    send(make_req(MODE_UNUSED_FIRST, TIMERS - 1, 15, 8'hff, NO_DEADLINE));
    send(make_req(MODE_UNUSED_FIRST + MODE_W'(1), 0, 0, 0, 0));
    send(make_req(MODE_UNUSED_LAST, TIMERS - 1, 15, 8'hff, NO_DEADLINE));
    send(make_req(MODE_FREE, TIMERS - 1, 0, 0, 0));

    // random sequences, with no idling over the last stretch
    directed_n = sent_cnt;
    quiet_from = directed_n + RANDOM_ITEMS - QUIET_TAIL;
    while (sent_cnt < directed_n + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (fills == 0 || (pick < 4 && fills < 3)) fill_table();
      else if (pick < 70) timer_burst();
      else random_item();
    end
    req_if.valid <= 1'b0;

    // drain the outstanding responses, then let a last scan settle
    do @(posedge clk); while (pending != 0);
    repeat (TIMERS + 8) @(posedge clk);

    $display("%0d requests sent: %0d slot grants, %0d table-full reports, %0d timer events",
             sent_cnt, grants, fulls, fired);
    $display("%0d table fills, idling on both channels except the last %0d requests",
             fills, QUIET_TAIL);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dttc_pkg.sv
rtl/dttc_if.sv
rtl/dttc_ram.sv
rtl/deadline_timer_table_core.sv
dv/timer_table_monitor.sv
dv/tb.sv
